// ===== rtl/core/rhsl_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSL converter.
// Depends on nothing; rhsl_front, rhsl_divider and rgb_to_hsl_unit import it.
`timescale 1ns / 1ps

package rhsl_pkg;

	// Width of every numerator and denominator handed to the divider.
	// The largest denominator is six times the channel spread (1530).
	localparam int DEN_W = 11;

	// Lightness divisor and the split point of the saturation formula.
	localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(510);
	localparam logic [8:0]       SAT_SPLIT = 9'd255;

	// One division lane: running partial remainder and its divisor.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} rhsl_lane_t;

	// The three divisions that one pixel needs, all started together.
	typedef struct packed {
		rhsl_lane_t hue;
		rhsl_lane_t sat;
		rhsl_lane_t light;
	} rhsl_div_req_t;

	// Result of one restoring division step.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic             qbit;
	} rhsl_step_t;

	// One restoring division step. The first step produces the integer bit
	// and compares without shifting; every later step shifts in a zero.
	function automatic rhsl_step_t div_step(input rhsl_lane_t lane, input logic first);
		logic [DEN_W:0] t;
		rhsl_step_t     r;
		t      = first ? {1'b0, lane.rem} : {lane.rem, 1'b0};
		r.qbit = (t >= {1'b0, lane.den});
		r.rem  = r.qbit ? DEN_W'(t - {1'b0, lane.den}) : t[DEN_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/rhsl_pixel_if.sv =====
// Request channel carrying one 8-bit RGB pixel with a valid/ready handshake.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface rhsl_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/rhsl_hsl_if.sv =====
// Request channel carrying one HSL result with a valid/ready handshake.
// Field widths follow the fraction width parameter.
`timescale 1ns / 1ps

interface rhsl_hsl_if #(parameter int FRAC_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] hue;
	logic [FRAC_BITS:0]   saturation;
	logic [FRAC_BITS:0]   lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

// ===== rtl/core/rhsl_front.sv =====
// Front end: finds the channel extremes, then forms the numerators and
// denominators of hue, saturation and lightness. Uses rhsl_pkg.
`timescale 1ns / 1ps

module rhsl_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	output logic                   req_valid,
	input  logic                   req_ready,
	output rhsl_pkg::rhsl_div_req_t req
);
	import rhsl_pkg::*;

	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	logic             v_s1, v_s2;
	logic             rdy_s1, rdy_s2;
	logic [7:0]       r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [1:0]       sel_s1;
	rhsl_div_req_t    req_s2;

	logic [7:0]       mx, mn;
	logic [1:0]       sel;
	logic [7:0]       d;
	logic [8:0]       sum;
	logic [DEN_W-1:0] d_w, r_w, g_w, b_w, six_d;
	rhsl_div_req_t    req_d;

	// A stage takes a new request when it is empty or its contents move on.
	assign rdy_s2   = ~v_s2 | req_ready;
	assign rdy_s1   = ~v_s1 | rdy_s2;
	assign in_ready = rdy_s1;

	// Largest and smallest channel; ties favor red, then green.
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sel = SEL_RED;
		end else if (mx == green) begin
			sel = SEL_GREEN;
		end else begin
			sel = SEL_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx;
			mn_s1  <= mn;
			sel_s1 <= sel;
		end
	end

	// Spread, sum and the sextant numerator of the hue.
	always_comb begin
		d     = mx_s1 - mn_s1;
		sum   = {1'b0, mx_s1} + {1'b0, mn_s1};
		d_w   = DEN_W'(d);
		r_w   = DEN_W'(r_s1);
		g_w   = DEN_W'(g_s1);
		b_w   = DEN_W'(b_s1);
		six_d = (d_w << 2) + (d_w << 1);

		case (sel_s1)
			SEL_RED: begin
				if (g_s1 >= b_s1) begin
					req_d.hue.rem = g_w - b_w;
				end else begin
					req_d.hue.rem = six_d - (b_w - g_w);
				end
			end
			SEL_GREEN: req_d.hue.rem = (d_w << 1) + b_w - r_w;
			SEL_BLUE:  req_d.hue.rem = (d_w << 2) + r_w - g_w;
			default:   req_d.hue.rem = '0;
		endcase
		req_d.hue.den = six_d;

		req_d.sat.rem = d_w;
		if (sum <= SAT_SPLIT) begin
			req_d.sat.den = DEN_W'(sum);
		end else begin
			req_d.sat.den = LIGHT_DEN - DEN_W'(sum);
		end

		// A grey pixel has no hue and no saturation.
		if (d == 8'd0) begin
			req_d.hue.rem = '0;
			req_d.hue.den = DEN_W'(1);
			req_d.sat.rem = '0;
			req_d.sat.den = DEN_W'(1);
		end

		req_d.light.rem = DEN_W'(sum);
		req_d.light.den = LIGHT_DEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			req_s2 <= req_d;
		end
	end

	assign req_valid = v_s2;
	assign req       = req_s2;

	// The hue numerator never reaches six times the spread.
	a_hue_below_turn: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (req_s2.hue.rem < req_s2.hue.den))
		else $error("hue numerator not below its divisor");

	// Saturation never exceeds one: its numerator is at most its divisor.
	a_sat_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (req_s2.sat.rem <= req_s2.sat.den))
		else $error("saturation numerator above its divisor");

endmodule

// ===== rtl/core/rhsl_divider.sv =====
// Pipelined restoring divider: three lanes share one valid bit and each
// stage resolves one quotient bit per lane. Uses rhsl_pkg.
`timescale 1ns / 1ps

module rhsl_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  rhsl_pkg::rhsl_div_req_t req,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [FRAC_BITS-1:0]    hue,
	output logic [FRAC_BITS:0]      saturation,
	output logic [FRAC_BITS:0]      lightness
);
	import rhsl_pkg::*;

	// One stage for the integer bit and one per fraction bit.
	localparam int STAGES = FRAC_BITS + 1;

	logic [STAGES-1:0] valid_s;
	logic [STAGES:0]   rdy;
	rhsl_div_req_t     lanes_s [STAGES];
	logic [FRAC_BITS:0] qh_s   [STAGES];
	logic [FRAC_BITS:0] qs_s   [STAGES];
	logic [FRAC_BITS:0] ql_s   [STAGES];

	assign rdy[STAGES] = out_ready;
	assign req_ready   = rdy[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic               v_in;
		rhsl_div_req_t      l_in;
		logic [FRAC_BITS:0] qh_in, qs_in, ql_in;
		rhsl_step_t         sh, ss, sl;

		// Previous stage, or the incoming request for the first one.
		if (k == 0) begin : g_head
			assign v_in  = req_valid;
			assign l_in  = req;
			assign qh_in = '0;
			assign qs_in = '0;
			assign ql_in = '0;
		end else begin : g_body
			assign v_in  = valid_s[k-1];
			assign l_in  = lanes_s[k-1];
			assign qh_in = qh_s[k-1];
			assign qs_in = qs_s[k-1];
			assign ql_in = ql_s[k-1];
		end

		assign rdy[k] = ~valid_s[k] | rdy[k+1];

		// One quotient bit per lane.
		always_comb begin
			sh = div_step(l_in.hue, k == 0);
			ss = div_step(l_in.sat, k == 0);
			sl = div_step(l_in.light, k == 0);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				lanes_s[k].hue   <= '{rem: sh.rem, den: l_in.hue.den};
				lanes_s[k].sat   <= '{rem: ss.rem, den: l_in.sat.den};
				lanes_s[k].light <= '{rem: sl.rem, den: l_in.light.den};
				qh_s[k]          <= {qh_in[FRAC_BITS-1:0], sh.qbit};
				qs_s[k]          <= {qs_in[FRAC_BITS-1:0], ss.qbit};
				ql_s[k]          <= {ql_in[FRAC_BITS-1:0], sl.qbit};
			end
		end
	end

	// The last stage doubles as the output register.
	assign out_valid  = valid_s[STAGES-1];
	assign hue        = qh_s[STAGES-1][FRAC_BITS-1:0];
	assign saturation = qs_s[STAGES-1];
	assign lightness  = ql_s[STAGES-1];

	// Hue lies below one full turn, so its integer bit stays clear.
	a_hue_int_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[STAGES-1] |-> !qh_s[STAGES-1][FRAC_BITS])
		else $error("hue quotient has an integer bit");

	// A saturation of one carries no fraction bits.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[STAGES-1] && saturation[FRAC_BITS]) |-> (saturation[FRAC_BITS-1:0] == '0))
		else $error("saturation above one");

	// A lightness of one carries no fraction bits.
	a_light_max: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[STAGES-1] && lightness[FRAC_BITS]) |-> (lightness[FRAC_BITS-1:0] == '0))
		else $error("lightness above one");

endmodule

// ===== rtl/core/rgb_to_hsl_unit.sv =====
// Top level of the RGB to HSL converter: front end plus pipelined divider.
// Depends on rhsl_pkg, rhsl_pixel_if, rhsl_hsl_if, rhsl_front, rhsl_divider.
`timescale 1ns / 1ps

// Usage
// The pixel channel takes one 8-bit RGB request; the result channel returns
// hue, saturation and lightness as unsigned fractions with FRAC_BITS
// fraction bits, truncated. Saturation and lightness are one bit wider so
// that the value one (full saturation, white) can be shown.
// From acceptance to a valid result a pixel passes two front-end stages,
// then one restoring-division stage per quotient bit (integer bit plus
// FRAC_BITS fraction bits), the last of which is the output register.
// While the receiver holds ready high, a new pixel can be accepted on every
// clock, so the sustained rate is one pixel per cycle.
// Reset clears every stage valid bit; the pipeline then stands empty and
// ready. When the receiver holds ready low, the result stays on the outputs
// unchanged, and stages behind it keep filling until they are full, so the
// pixel channel drops ready only once every stage holds a request.
// Each result follows its pixel in order; none is lost or repeated.

module rgb_to_hsl_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rhsl_pixel_if.sink    pix,
	rhsl_hsl_if.source    hsl
);
	import rhsl_pkg::*;

	logic          req_valid;
	logic          req_ready;
	rhsl_div_req_t req;

	// Extremes, spread and the three numerator/divisor pairs.
	rhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.red       (pix.red),
		.green     (pix.green),
		.blue      (pix.blue),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	// One quotient bit per stage for all three outputs.
	rhsl_divider #(
		.FRAC_BITS (FRAC_BITS)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.out_valid  (hsl.valid),
		.out_ready  (hsl.ready),
		.hue        (hsl.hue),
		.saturation (hsl.saturation),
		.lightness  (hsl.lightness)
	);

endmodule

// ===== bench/rgb_to_hsl_unit_tb.sv =====
// Self-checking bench for rgb_to_hsl_unit: pixel requests in, HSL requests out,
// each result checked against a bit-exact integer predictor. Needs rhsl_pixel_if,
// rhsl_hsl_if and the converter RTL; reads no files.
`timescale 1ns / 1ps

module rgb_to_hsl_unit_tb;

	localparam int FB          = 16;
	localparam int LATENCY     = FB + 3;
	localparam int MAX_GAP     = 12;
	localparam int RANDOM_PIX  = 450;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FB-1:0] hue;
		logic [FB:0]   saturation;
		logic [FB:0]   lightness;
	} hsl_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side registers behind the block inputs, known from time zero.
	logic       drv_valid = 1'b0;
	logic [7:0] drv_red   = '0;
	logic [7:0] drv_green = '0;
	logic [7:0] drv_blue  = '0;
	logic       take_ready = 1'b0;

	pixel_t pixel_queue[$];
	hsl_t   hsl_expected[$];
	int     failures    = 0;
	int     sent_count  = 0;
	int     got_count   = 0;
	int     cycle_count = 0;
	int     hold_off    = 0;
	int     stall_left  = 0;

	rhsl_pixel_if             pix_if ();
	rhsl_hsl_if #(.FRAC_BITS(FB)) hsl_if ();

	assign pix_if.valid = drv_valid;
	assign pix_if.red   = drv_red;
	assign pix_if.green = drv_green;
	assign pix_if.blue  = drv_blue;
	assign hsl_if.ready = take_ready;

	rgb_to_hsl_unit #(.FRAC_BITS(FB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.hsl    (hsl_if)
	);

	always #1 clk = ~clk;

	// Exact integer HSL of one pixel, truncated to the output widths.
	function automatic hsl_t predict_hsl(input pixel_t p);
		logic [63:0] r, g, b, mx, mn, sum, spread, num, den;
		hsl_t        res;
		r   = 64'(p.red);
		g   = 64'(p.green);
		b   = 64'(p.blue);
		mx  = r;
		mn  = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum    = mx + mn;
		spread = mx - mn;
		res    = '0;
		res.lightness = (FB+1)'((sum << FB) / 64'd510);
		if (spread != 0) begin
			den = (sum <= 64'd255) ? sum : 64'd510 - sum;
			res.saturation = (FB+1)'((spread << FB) / den);
			// Sextant of the largest channel, red winning ties, then green.
			if (mx == r) begin
				num = (g < b) ? 6 * spread - (b - g) : g - b;
			end else if (mx == g) begin
				num = 2 * spread + b - r;
			end else begin
				num = 4 * spread + r - g;
			end
			res.hue = FB'((num << FB) / (6 * spread));
		end
		return res;
	endfunction

	function automatic int draw_wait(input int count, input int period, input int calm);
		return (count % period < calm) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic queue_pixel(input int r, input int g, input int b);
		pixel_queue.push_back('{red: 8'(r), green: 8'(g), blue: 8'(b)});
	endtask

	// Places three channel values on the pixel in one of three rotations.
	task automatic queue_rotated(input int a, input int b, input int c, input int rot);
		case (rot)
			0: queue_pixel(a, b, c);
			1: queue_pixel(c, a, b);
			default: queue_pixel(b, c, a);
		endcase
	endtask

	function automatic int extreme_value();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1;
			2: return 254;
			3: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Random pixels: mostly uniform, with greys, tied maxima, extreme channels
	// and pixels whose max+min sits at the saturation split.
	task automatic queue_random_pixels(input int count);
		int hi, lo, mid;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				6: begin
					hi = $urandom_range(0, 255);
					queue_pixel(hi, hi, hi);
				end
				7: begin
					hi = $urandom_range(1, 255);
					lo = $urandom_range(0, hi);
					queue_rotated(hi, hi, lo, $urandom_range(0, 2));
				end
				8: queue_pixel(extreme_value(), extreme_value(), extreme_value());
				9: begin
					hi  = $urandom_range(128, 255);
					lo  = 255 - hi + $urandom_range(0, 1);
					if (lo > hi) lo = hi;
					mid = $urandom_range(lo, hi);
					queue_rotated(hi, mid, lo, $urandom_range(0, 2));
				end
				default: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			endcase
		end
	endtask

	// Pixel driver: holds each request until accepted, then waits a drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			hold_off  = 0;
		end else begin
			if (drv_valid && pix_if.ready) begin
				hsl_expected.push_back(predict_hsl('{red: drv_red, green: drv_green,
					blue: drv_blue}));
				sent_count++;
			end
			if (!drv_valid || pix_if.ready) begin
				if (hold_off > 0) begin
					drv_valid <= 1'b0;
					hold_off--;
				end else if (pixel_queue.size() != 0) begin
					pixel_t p;
					p = pixel_queue.pop_front();
					drv_red   <= p.red;
					drv_green <= p.green;
					drv_blue  <= p.blue;
					drv_valid <= 1'b1;
					hold_off  = draw_wait(sent_count, 96, 32);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted request, then stalls a drawn time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (hsl_if.valid && take_ready) begin
				got_count++;
				if (hsl_expected.size() == 0) begin
					$error("unexpected result: hue %0d saturation %0d lightness %0d",
						hsl_if.hue, hsl_if.saturation, hsl_if.lightness);
					failures++;
				end else begin
					hsl_t want;
					want = hsl_expected.pop_front();
					if (hsl_if.hue !== want.hue) begin
						$error("hue: expected %0d, actual %0d", want.hue, hsl_if.hue);
						failures++;
					end
					if (hsl_if.saturation !== want.saturation) begin
						$error("saturation: expected %0d, actual %0d",
							want.saturation, hsl_if.saturation);
						failures++;
					end
					if (hsl_if.lightness !== want.lightness) begin
						$error("lightness: expected %0d, actual %0d",
							want.lightness, hsl_if.lightness);
						failures++;
					end
				end
				stall_left = draw_wait(got_count, 80, 24);
			end
			if (stall_left > 0) begin
				take_ready <= 1'b0;
				stall_left--;
			end else begin
				take_ready <= 1'b1;
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		// Directed pixels: black, white, primaries, ties, greys, split edges.
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(255, 0, 0);
		queue_pixel(0, 255, 0);
		queue_pixel(0, 0, 255);
		queue_pixel(255, 255, 0);
		queue_pixel(0, 255, 255);
		queue_pixel(255, 0, 255);
		queue_pixel(128, 128, 128);
		queue_pixel(1, 0, 0);
		queue_pixel(255, 254, 254);
		queue_pixel(128, 127, 127);
		queue_pixel(128, 128, 127);
		queue_pixel(129, 127, 127);
		queue_pixel(200, 10, 50);
		queue_pixel(200, 50, 10);
		queue_pixel(10, 200, 50);
		queue_pixel(50, 10, 200);
		queue_pixel(255, 0, 1);
		queue_pixel(1, 2, 3);
		queue_pixel(8'hAA, 8'h55, 8'h0F);
		queue_pixel(8'h55, 8'hAA, 8'hF0);
		queue_random_pixels(RANDOM_PIX);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_queue.size() != 0 || drv_valid) @(posedge clk);
		while (hsl_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
